@@ hw/rtl/g2km_pkg.sv @@
`default_nettype none

package g2km_pkg;

    // Field and register widths.
    localparam int AXIS_W     = 16;
    localparam int DZ_W       = 15;
    localparam int THR_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam int MOVE_W     = 5;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_DZ  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_DZ = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_THR = 2'd2;

    localparam logic [DZ_W-1:0]  LEFT_DZ_RST  = 15'd7849;
    localparam logic [DZ_W-1:0]  RIGHT_DZ_RST = 15'd8689;
    localparam logic [THR_W-1:0] TRIG_THR_RST = 8'd30;

    // Full scale of a stick axis, and the range of a mouse move.
    localparam logic [DZ_W-1:0] AXIS_FULL = 15'h7FFF;
    localparam logic [3:0]      MOVE_MIN  = 4'd4;
    localparam logic [3:0]      MOVE_MAX  = 4'd12;

    // Event kinds.
    localparam logic [1:0] KIND_KEY    = 2'd0;
    localparam logic [1:0] KIND_RETURN = 2'd1;
    localparam logic [1:0] KIND_MOUSE  = 2'd2;
    localparam logic [1:0] KIND_MOVE   = 2'd3;

    localparam logic [7:0] RETURN_SCANCODE = 8'h1C;

    // Pad button bit positions.
    localparam int BTN_UP        = 0;
    localparam int BTN_DOWN      = 1;
    localparam int BTN_LEFT      = 2;
    localparam int BTN_RIGHT     = 3;
    localparam int BTN_START     = 4;
    localparam int BTN_BACK      = 5;
    localparam int BTN_RTHUMB    = 7;
    localparam int BTN_LSHOULDER = 8;
    localparam int BTN_RSHOULDER = 9;
    localparam int BTN_A         = 12;
    localparam int BTN_B         = 13;
    localparam int BTN_X         = 14;
    localparam int BTN_Y         = 15;

    // Targets: the 16 keys in ascending key-code order, the two mouse
    // buttons, the Return scancode and the mouse move.
    localparam int N_KEYS = 16;
    localparam int N_TGT  = 19;
    localparam int N_SLOT = 20;
    localparam int TGT_W  = $clog2(N_SLOT);

    typedef logic [TGT_W-1:0] t_tgt;
    typedef logic signed [MOVE_W-1:0] t_move;

    localparam t_tgt T_TAB     = 5'd0;
    localparam t_tgt T_SPACE   = 5'd1;
    localparam t_tgt T_1       = 5'd2;
    localparam t_tgt T_2       = 5'd3;
    localparam t_tgt T_3       = 5'd4;
    localparam t_tgt T_A       = 5'd5;
    localparam t_tgt T_C       = 5'd6;
    localparam t_tgt T_D       = 5'd7;
    localparam t_tgt T_I       = 5'd8;
    localparam t_tgt T_M       = 5'd9;
    localparam t_tgt T_R       = 5'd10;
    localparam t_tgt T_S       = 5'd11;
    localparam t_tgt T_V       = 5'd12;
    localparam t_tgt T_W       = 5'd13;
    localparam t_tgt T_X       = 5'd14;
    localparam t_tgt T_Z       = 5'd15;
    localparam t_tgt T_MOUSE_L = 5'd16;
    localparam t_tgt T_MOUSE_R = 5'd17;
    localparam t_tgt T_RETURN  = 5'd18;
    localparam t_tgt T_MOVE    = 5'd19;

    localparam logic [7:0] KEY_CODES [N_KEYS] = '{
        8'h09, 8'h20, 8'h31, 8'h32, 8'h33, 8'h41, 8'h43, 8'h44,
        8'h49, 8'h4D, 8'h52, 8'h53, 8'h56, 8'h57, 8'h58, 8'h5A
    };

    // Order in which a sample reports its events.
    localparam t_tgt SAMPLE_ORDER [N_SLOT] = '{
        T_A, T_D, T_W, T_S, T_MOVE, T_SPACE, T_1, T_2, T_3, T_X,
        T_TAB, T_MOUSE_L, T_MOUSE_R, T_M, T_RETURN, T_R, T_C, T_I, T_V, T_Z
    };

    // Divider control and status.
    typedef struct packed {
        logic start;
        logic negate;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

    // Result of the pending-event search.
    typedef struct packed {
        logic found;
        logic last;
        t_tgt slot;
    } t_pick;

endpackage

`default_nettype wire

@@ hw/rtl/g2km_ifs.sv @@
`default_nettype none

// Input channel: one gamepad sample or release command per beat.
interface g2km_item_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [15:0]        buttons;
    logic [7:0]         left_trigger;
    logic [7:0]         right_trigger;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;

    modport source (
        output valid, mode, buttons, left_trigger, right_trigger,
               left_x, left_y, right_x, right_y,
        input  ready
    );
    modport sink (
        input  valid, mode, buttons, left_trigger, right_trigger,
               left_x, left_y, right_x, right_y,
        output ready
    );
endinterface

// Output channel: one key, button or mouse event per beat.
interface g2km_event_if;
    logic              valid;
    logic              ready;
    logic [1:0]        event_kind;
    logic [7:0]        event_code;
    logic              pressed;
    logic signed [4:0] move_x;
    logic signed [4:0] move_y;
    logic              last;

    modport source (
        output valid, event_kind, event_code, pressed, move_x, move_y, last,
        input  ready
    );
    modport sink (
        input  valid, event_kind, event_code, pressed, move_x, move_y, last,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/g2km_div.sv @@
`default_nettype none

// Serial restoring divider that turns one stick axis into a mouse move
// count. One quotient bit is resolved per cycle.
module g2km_div import g2km_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_div_req                 i_req,
    input  wire logic signed [AXIS_W-1:0] i_axis,
    input  wire logic [DZ_W-1:0]          i_dz,
    output t_div_sts                      o_sts,
    output t_move                         o_move
);

    localparam int MAG_W = AXIS_W + 1;
    localparam int REM_W = AXIS_W + 3;
    localparam int QUO_W = 5;
    localparam int CNT_W = $clog2(QUO_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [REM_W-1:0]   r_rem;
    logic [REM_W-1:0]   r_div;
    logic [QUO_W-1:0]   r_q;
    logic               r_neg;
    logic               r_inside;
    logic               r_full;

    logic [MAG_W-1:0]   w_ext;
    logic [MAG_W-1:0]   w_mag;
    logic [MAG_W-1:0]   w_diff;
    logic [DZ_W-1:0]    w_span;
    logic               w_inside;
    logic [REM_W:0]     w_trial;
    logic [3:0]         w_count;
    logic [MOVE_W-1:0]  w_pos;

    // Magnitude of the axis and its distance beyond the deadzone.
    assign w_ext    = {i_axis[AXIS_W-1], i_axis};
    assign w_mag    = i_axis[AXIS_W-1] ? (~w_ext + MAG_W'(1)) : w_ext;
    assign w_inside = w_mag < {2'b00, i_dz};
    assign w_diff   = w_mag - {2'b00, i_dz};
    assign w_span   = AXIS_FULL - i_dz;

    // One trial subtraction per cycle.
    assign w_trial = {1'b0, r_rem} - {1'b0, r_div};

    // Control: start, step count and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUO_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    // Datapath: scaled remainder, shifting divisor and quotient.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem    <= {w_diff[AXIS_W-1:0], 3'b000};
            r_div    <= {w_span, 4'b0000};
            r_q      <= '0;
            r_neg    <= i_axis[AXIS_W-1] ^ i_req.negate;
            r_inside <= w_inside;
            r_full   <= (w_span == '0);
        end else if (r_busy) begin
            if (!w_trial[REM_W]) begin
                r_rem <= w_trial[REM_W-1:0];
            end
            r_q   <= {r_q[QUO_W-2:0], ~w_trial[REM_W]};
            r_div <= r_div >> 1;
        end
    end

    // Offset, saturation and sign of the finished count.
    always_comb begin
        if (r_inside) begin
            w_count = 4'd0;
        end else if (r_full || (r_q >= QUO_W'(8))) begin
            w_count = MOVE_MAX;
        end else begin
            w_count = MOVE_MIN + {1'b0, r_q[2:0]};
        end
    end

    assign w_pos  = {1'b0, w_count};
    assign o_move = r_neg ? (MOVE_W'(0) - w_pos) : w_pos;

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

`default_nettype wire

@@ hw/rtl/g2km_pick.sv @@
`default_nettype none

// Finds the first pending event slot and tells whether it is the only one.
module g2km_pick import g2km_pkg::*; (
    input  wire logic [N_SLOT-1:0] i_pend,
    output t_pick                  o_pick
);

    always_comb begin
        o_pick.slot = '0;
        for (int i = N_SLOT - 1; i >= 0; i--) begin
            if (i_pend[i]) begin
                o_pick.slot = TGT_W'(i);
            end
        end
        o_pick.found = |i_pend;
        o_pick.last  = (i_pend & (i_pend - N_SLOT'(1))) == '0;
    end

endmodule

`default_nettype wire

@@ hw/rtl/gamepad_to_key_mouse_events.sv @@
`default_nettype none

// Gamepad to key and mouse event translator. Each input beat is a pad
// sample (mode 0) or a release command (mode 1); the block answers with
// zero to twenty event beats, the final one marked by last, and reports a
// key, mouse button or Return press only when its held flag changes. The
// block takes one input beat at a time and is not ready until every event
// of that beat has been loaded into the output register. A sample passes
// through the shared serial divider, which scales first the right stick x
// and then y axis (five quotient bits and a done pulse per axis). The
// block then gathers the pending events and emits one event per cycle
// while the output is not stalled, then returns to ready. A release
// command skips the divider. Configuration writes take effect at the next
// clock edge and belong between beats, while the block is idle.
module gamepad_to_key_mouse_events import g2km_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    g2km_item_if.sink                  i_item,
    g2km_event_if.source               o_event,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_MASK = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic                r_axis, n_axis;
    logic [N_SLOT-1:0]   r_pend, n_pend;
    logic [N_TGT-1:0]    r_held, n_held;
    logic                r_out_valid, n_out_valid;

    logic [DZ_W-1:0]     r_ldz;
    logic [DZ_W-1:0]     r_rdz;
    logic [THR_W-1:0]    r_thr;

    logic                r_mode;
    logic [N_TGT-1:0]    r_want;
    logic [AXIS_W-1:0]   r_ry;
    t_move               r_dx;
    t_move               r_dy;

    logic [1:0]          r_out_kind;
    logic [7:0]          r_out_code;
    logic                r_out_pressed;
    t_move               r_out_mx;
    t_move               r_out_my;
    logic                r_out_last;

    logic                w_accept;
    logic [N_TGT-1:0]    w_want;
    logic signed [16:0]  w_ldz;
    logic signed [16:0]  w_lx;
    logic signed [16:0]  w_ly;
    t_div_req            w_div_req;
    t_div_sts            w_div_sts;
    logic [AXIS_W-1:0]   w_div_axis;
    t_move               w_div_move;
    logic [N_SLOT-1:0]   w_tpend;
    logic [N_SLOT-1:0]   w_slot_pend;
    t_pick               w_pick;
    t_tgt                w_tgt;
    logic [N_SLOT-1:0]   w_want_all;
    logic                w_load;
    logic [1:0]          w_kind;
    logic [7:0]          w_code;

    assign i_item.ready = (r_state == ST_IDLE);
    assign w_accept     = i_item.valid && i_item.ready;

    // Desired held flags of a sample; a release command wants all clear.
    assign w_ldz = {2'b00, r_ldz};
    assign w_lx  = {i_item.left_x[AXIS_W-1], i_item.left_x};
    assign w_ly  = {i_item.left_y[AXIS_W-1], i_item.left_y};

    always_comb begin
        w_want            = '0;
        w_want[T_TAB]     = i_item.buttons[BTN_RSHOULDER];
        w_want[T_SPACE]   = i_item.buttons[BTN_A];
        w_want[T_1]       = i_item.buttons[BTN_X];
        w_want[T_2]       = i_item.buttons[BTN_Y];
        w_want[T_3]       = i_item.buttons[BTN_B];
        w_want[T_A]       = w_lx < -w_ldz;
        w_want[T_C]       = i_item.buttons[BTN_DOWN];
        w_want[T_D]       = w_lx > w_ldz;
        w_want[T_I]       = i_item.buttons[BTN_LEFT];
        w_want[T_M]       = i_item.buttons[BTN_BACK];
        w_want[T_R]       = i_item.buttons[BTN_UP];
        w_want[T_S]       = w_ly < -w_ldz;
        w_want[T_V]       = i_item.buttons[BTN_RIGHT];
        w_want[T_W]       = w_ly > w_ldz;
        w_want[T_X]       = i_item.buttons[BTN_LSHOULDER];
        w_want[T_Z]       = i_item.buttons[BTN_RTHUMB];
        w_want[T_MOUSE_L] = i_item.right_trigger > r_thr;
        w_want[T_MOUSE_R] = i_item.left_trigger > r_thr;
        w_want[T_RETURN]  = i_item.buttons[BTN_START];
        if (i_item.mode) begin
            w_want = '0;
        end
    end

    // The divider scales x at accept time and y once x is done.
    assign w_div_req.start  = (w_accept && !i_item.mode)
                           || ((r_state == ST_DIV) && w_div_sts.done && !r_axis);
    assign w_div_req.negate = (r_state == ST_DIV);
    assign w_div_axis       = (r_state == ST_IDLE) ? i_item.right_x : r_ry;

    g2km_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .i_axis  (w_div_axis),
        .i_dz    (r_rdz),
        .o_sts   (w_div_sts),
        .o_move  (w_div_move)
    );

    // Pending targets, arranged in report order for a sample and in target order for a release.
    always_comb begin
        w_tpend              = '0;
        w_tpend[N_TGT-1:0]   = r_want ^ r_held;
        w_tpend[T_MOVE]      = !r_mode && ((r_dx != '0) || (r_dy != '0));
        if (r_mode) begin
            w_slot_pend = {1'b0, w_tpend[N_TGT-1:0]};
        end else begin
            for (int s = 0; s < N_SLOT; s++) begin
                w_slot_pend[s] = w_tpend[SAMPLE_ORDER[s]];
            end
        end
    end

    g2km_pick u_pick (
        .i_pend (r_pend),
        .o_pick (w_pick)
    );

    // Event of the first pending slot.
    assign w_tgt      = r_mode ? w_pick.slot : SAMPLE_ORDER[w_pick.slot];
    assign w_want_all = {1'b0, r_want};
    assign w_load     = (r_state == ST_EMIT) && w_pick.found
                     && (!r_out_valid || o_event.ready);

    always_comb begin
        if (w_tgt == T_MOVE) begin
            w_kind = KIND_MOVE;
            w_code = 8'h00;
        end else if (w_tgt == T_RETURN) begin
            w_kind = KIND_RETURN;
            w_code = RETURN_SCANCODE;
        end else if ((w_tgt == T_MOUSE_L) || (w_tgt == T_MOUSE_R)) begin
            w_kind = KIND_MOUSE;
            w_code = {7'b0, w_tgt == T_MOUSE_R};
        end else begin
            w_kind = KIND_KEY;
            w_code = KEY_CODES[w_tgt[3:0]];
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        n_pend      = r_pend;
        n_held      = r_held;
        n_out_valid = r_out_valid && !o_event.ready;
        unique case (r_state)
            ST_IDLE: begin
                n_axis = 1'b0;
                if (w_accept) begin
                    n_state = i_item.mode ? ST_MASK : ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_sts.done) begin
                    n_axis = 1'b1;
                    if (r_axis) begin
                        n_state = ST_MASK;
                    end
                end
            end
            ST_MASK: begin
                n_pend  = w_slot_pend;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_pend      = r_pend & ~(N_SLOT'(1) << w_pick.slot);
                    for (int i = 0; i < N_TGT; i++) begin
                        if (w_tgt == TGT_W'(i)) begin
                            n_held[i] = r_want[i];
                        end
                    end
                    if (w_pick.last) begin
                        n_state = ST_IDLE;
                    end
                end else if (!w_pick.found) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_axis      <= 1'b0;
            r_pend      <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
            r_ldz       <= LEFT_DZ_RST;
            r_rdz       <= RIGHT_DZ_RST;
            r_thr       <= TRIG_THR_RST;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_pend      <= n_pend;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_LEFT_DZ:  r_ldz <= i_cfg_data;
                    CFG_RIGHT_DZ: r_rdz <= i_cfg_data;
                    CFG_TRIG_THR: r_thr <= i_cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Item payload, move counts and the output register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_item.mode;
            r_want <= w_want;
            r_ry   <= i_item.right_y;
            r_dx   <= '0;
            r_dy   <= '0;
        end else if ((r_state == ST_DIV) && w_div_sts.done) begin
            if (r_axis) begin
                r_dy <= w_div_move;
            end else begin
                r_dx <= w_div_move;
            end
        end
        if (w_load) begin
            r_out_kind    <= w_kind;
            r_out_code    <= w_code;
            r_out_pressed <= w_want_all[w_tgt];
            r_out_mx      <= (w_tgt == T_MOVE) ? r_dx : '0;
            r_out_my      <= (w_tgt == T_MOVE) ? r_dy : '0;
            r_out_last    <= w_pick.last;
        end
    end

    assign o_event.valid      = r_out_valid;
    assign o_event.event_kind = r_out_kind;
    assign o_event.event_code = r_out_code;
    assign o_event.pressed    = r_out_pressed;
    assign o_event.move_x     = r_out_mx;
    assign o_event.move_y     = r_out_my;
    assign o_event.last       = r_out_last;

    // No event may be left pending once the sequencer is back at rest.
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_pend == '0))
        else $error("pending events left while idle");

    // A new item never arrives while the divider still works.
    a_ready_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.ready |-> !w_div_sts.busy)
        else $error("input ready while divider busy");

    // Every press or release event flips exactly its held flag.
    a_held_flips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (w_tgt != T_MOVE)) |=> ($countones(r_held ^ $past(r_held)) == 1))
        else $error("key event without a held flag change");

    // A move event carries movement within the saturated range.
    a_move_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == KIND_MOVE))
        |-> (((r_out_mx != '0) || (r_out_my != '0))
             && (r_out_mx <= 5'sd12) && (r_out_mx >= -5'sd12)
             && (r_out_my <= 5'sd12) && (r_out_my >= -5'sd12)))
        else $error("mouse move out of range");

endmodule

`default_nettype wire
